// ===== hdl/mhsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mhsd_pkg
// shared types and codes for the max-heap sift-down engine
// ----------------------------------------------------------------------------
package mhsd_pkg;

    // command codes on the input request
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SIFT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned SWP_W  = 4;
    localparam int unsigned HSZ_W  = 11;
    localparam int unsigned OUT_DW = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_PAR,
        ST_LEFT,
        ST_RIGHT,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/mhsd_ram.sv =====
// ----------------------------------------------------------------------------
// mhsd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mhsd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/max_heap_sift_down.sv =====
// ----------------------------------------------------------------------------
// max_heap_sift_down
// binary max-heap held in one ram, with write, read and sift-down commands
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | request   | i_in_valid / o_in_ready   | command, index, value
//  out     | result    | o_out_valid / i_out_ready | read_value, final_position,
//          |           |                           | swap_count
//  cfg     | request   | i_cfg_valid / o_cfg_ready | heap_size
//
//  ram port: sift-down reads the children of each slot on the walk through the
//  single ram read port, one child per cycle
//  reset: synchronous active-low clears control and heap_size; ram is not cleared
//  stalls: a new request is taken while a finished result still waits in the
//  output register; the engine holds before loading the next result
//
// ----------------------------------------------------------------------------
module max_heap_sift_down
    import mhsd_pkg::*;
#(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_command,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [OUT_DW-1:0] i_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_DW-1:0] o_read_value,
    output logic [IDX_W-1:0]         o_final_position,
    output logic [SWP_W-1:0]         o_swap_count,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [HSZ_W-1:0]         i_cfg_heap_size
);

    // address width of the ram, walk index width and child index width
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;
    localparam int unsigned CW = IW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    t_state r_state, n_state;

    logic [HSZ_W-1:0]             r_heap_size;
    logic [IW-1:0]                r_i, n_i;
    logic [SWP_W-1:0]             r_swaps, n_swaps;
    logic signed [OUT_DW-1:0]     r_rdv, n_rdv;
    logic signed [DATA_WIDTH-1:0] r_elem, n_elem;
    logic signed [DATA_WIDTH-1:0] r_best, n_best;
    logic                         r_lbig, n_lbig;
    logic                         r_rok, n_rok;

    // output register
    logic                         r_ovalid;
    logic signed [OUT_DW-1:0]     r_o_rdv;
    logic [IDX_W-1:0]             r_o_pos;
    logic [SWP_W-1:0]             r_o_swp;

    // ram port signals
    logic                         w_we, w_re;
    logic [AW-1:0]                w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0]        w_wdata, w_rdata;
    logic signed [DATA_WIDTH-1:0] w_rd;

    // walk helpers
    logic [CW-1:0]                w_n;
    logic [CW-1:0]                w_idx_c;
    logic [CW-1:0]                w_lc, w_rc, w_big, w_nlc;
    logic                         w_in_fire, w_load, w_rbig, w_swap, w_more;
    logic signed [DATA_WIDTH-1:0] w_big_val;

    assign w_in_fire = i_in_valid & o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_rd = $signed(w_rdata);

    // effective heap size never goes past the memory
    assign w_n     = (CW'(r_heap_size) > DEPTH_C) ? DEPTH_C : CW'(r_heap_size);
    assign w_idx_c = CW'(i_index);

    // children of the current slot
    assign w_lc = {r_i, 1'b1};
    assign w_rc = w_lc + CW'(1);

    // right child wins only when strictly above the best of parent and left
    assign w_rbig    = r_rok && (w_rd > r_best);
    assign w_swap    = w_rbig || r_lbig;
    assign w_big     = w_rbig ? w_rc : w_lc;
    assign w_big_val = w_rbig ? w_rd : r_best;
    assign w_nlc     = {w_big[IW-1:0], 1'b1};
    assign w_more    = (w_nlc < w_n);

    // result goes to the output register when it is free or being drained
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    case (i_command)
                        CMD_READ: begin
                            n_state = (w_idx_c < DEPTH_C) ? ST_RD : ST_OUT;
                        end
                        CMD_SIFT: begin
                            n_state = (w_idx_c < w_n) ? ST_PAR : ST_OUT;
                        end
                        default: begin
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_PAR: begin
                n_state = (w_lc < w_n) ? ST_LEFT : ST_FIN;
            end
            ST_LEFT: begin
                n_state = ST_RIGHT;
            end
            ST_RIGHT: begin
                n_state = (w_swap && w_more) ? ST_LEFT : ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_i     = r_i;
        n_swaps = r_swaps;
        n_rdv   = r_rdv;
        n_elem  = r_elem;
        n_best  = r_best;
        n_lbig  = r_lbig;
        n_rok   = r_rok;
        w_we    = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wdata = r_elem;
        w_re    = 1'b0;
        w_raddr = r_i[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_i     = IW'(i_index);
                    n_swaps = '0;
                    n_rdv   = '0;
                    w_waddr = AW'(i_index);
                    w_raddr = AW'(i_index);
                    w_wdata = DATA_WIDTH'(i_value);
                    case (i_command)
                        CMD_WRITE: begin
                            w_we = (w_idx_c < DEPTH_C);
                        end
                        CMD_READ: begin
                            w_re = (w_idx_c < DEPTH_C);
                        end
                        CMD_SIFT: begin
                            w_re = (w_idx_c < w_n);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_rdv = OUT_DW'(w_rd);
            end
            ST_PAR: begin
                // the sifted element rides in a register until it settles
                n_elem  = w_rd;
                w_re    = (w_lc < w_n);
                w_raddr = w_lc[AW-1:0];
            end
            ST_LEFT: begin
                n_lbig  = (w_rd > r_elem);
                n_best  = (w_rd > r_elem) ? w_rd : r_elem;
                n_rok   = (w_rc < w_n);
                w_re    = (w_rc < w_n);
                w_raddr = w_rc[AW-1:0];
            end
            ST_RIGHT: begin
                if (w_swap) begin
                    // larger child moves up, walk follows it down
                    w_we    = 1'b1;
                    w_waddr = r_i[AW-1:0];
                    w_wdata = w_big_val;
                    n_i     = w_big[IW-1:0];
                    n_swaps = r_swaps + SWP_W'(1);
                    w_re    = w_more;
                    w_raddr = w_nlc[AW-1:0];
                end
            end
            ST_FIN: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_elem;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_heap_size <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_size <= i_cfg_heap_size;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_swaps <= n_swaps;
        r_rdv   <= n_rdv;
        r_elem  <= n_elem;
        r_best  <= n_best;
        r_lbig  <= n_lbig;
        r_rok   <= n_rok;
        if (w_load) begin
            r_o_rdv <= r_rdv;
            r_o_pos <= r_i[IDX_W-1:0];
            r_o_swp <= r_swaps;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_read_value     = r_o_rdv;
    assign o_final_position = r_o_pos;
    assign o_swap_count     = r_o_swp;

    mhsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

`ifndef SYNTH
    // the walk never reads the slot it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && (w_waddr == w_raddr)))
        else $error("ram read and write hit the same slot");

    // while walking, the current slot stays inside the heap
    a_walk_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LEFT) || (r_state == ST_RIGHT) || (r_state == ST_FIN))
        |-> (CW'(r_i) < w_n))
        else $error("sift walk left the heap");

    // each swap at least doubles the slot, so swaps stay within the tree depth
    a_swap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (int'(r_swaps) <= AW))
        else $error("swap count beyond tree depth");

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !w_in_fire)
        else $error("request taken while busy");
`endif

endmodule

// ===== test/tb_max_heap_sift_down.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_sift_down
// self-checking bench for the max-heap sift-down engine: write, read, sift-down
// and unused-command requests go through a scoreboard that keeps its own heap
// image; heap sizes swept from empty to past the memory depth, with random
// gaps on both channels, a steady stretch and one long output stall
// ----------------------------------------------------------------------------
module tb_max_heap_sift_down
    import mhsd_pkg::*;
();

    localparam int unsigned HEAP_DEPTH    = 1024;
    localparam int unsigned IDLE_PCT      = 19;
    localparam int unsigned STALL_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned TIMEOUT_NS    = 1000000;

    // the block ignores the fourth command code
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [OUT_DW-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [OUT_DW-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [OUT_DW-1:0] read_value;
        logic [IDX_W-1:0]         final_position;
        logic [SWP_W-1:0]         swap_count;
    } t_heap_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_command;
    logic [IDX_W-1:0]         i_index;
    logic signed [OUT_DW-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [OUT_DW-1:0] o_read_value;
    logic [IDX_W-1:0]         o_final_position;
    logic [SWP_W-1:0]         o_swap_count;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [HSZ_W-1:0]         i_cfg_heap_size;

    // scoreboard copy of the heap ram and the size register
    logic signed [OUT_DW-1:0] heap_image [HEAP_DEPTH];
    bit                       slot_written [HEAP_DEPTH];
    logic [HSZ_W-1:0]         heap_size_reg;
    t_heap_result             pending_results [$];

    // traffic shaping shared between the request side and the result side
    bit steady_in;
    bit steady_out;
    bit stall_request;

    // run statistics
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned write_count;
    int unsigned read_count;
    int unsigned sift_count;
    int unsigned unused_count;
    int unsigned deepest_swaps;
    int unsigned stalls_done;

    max_heap_sift_down #(
        .DEPTH      (HEAP_DEPTH),
        .DATA_WIDTH (OUT_DW)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_index          (i_index),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_value     (o_read_value),
        .o_final_position (o_final_position),
        .o_swap_count     (o_swap_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_heap_size  (i_cfg_heap_size)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // heap predictor
    // ------------------------------------------------------------------------

    // sizes above the memory depth clamp to the depth
    function automatic int unsigned effective_size();
        return (heap_size_reg > HEAP_DEPTH) ? HEAP_DEPTH : int'(heap_size_reg);
    endfunction

    // dry run of a sift-down: returns the first never-written slot the walk
    // would compare, or -1 when the whole walk stays on written slots
    function automatic int first_unfilled_on_walk(input int unsigned start);
        int unsigned              n;
        int unsigned              pos;
        int unsigned              left;
        int unsigned              right;
        int unsigned              big;
        logic signed [OUT_DW-1:0] moving;
        logic signed [OUT_DW-1:0] big_val;
        n = effective_size();
        pos = start;
        if (pos >= n) return -1;
        if (!slot_written[pos]) return pos;
        // the sifted element travels down, so children compare against it
        moving = heap_image[pos];
        forever begin
            left    = 2 * pos + 1;
            right   = 2 * pos + 2;
            big     = pos;
            big_val = moving;
            if (left < n) begin
                if (!slot_written[left]) return left;
                if (heap_image[left] > big_val) begin
                    big     = left;
                    big_val = heap_image[left];
                end
            end
            if (right < n) begin
                if (!slot_written[right]) return right;
                if (heap_image[right] > big_val) big = right;
            end
            if (big == pos) return -1;
            pos = big;
        end
    endfunction

    // applies one request to the heap image and returns its result
    function automatic t_heap_result predict_heap_step(input logic [1:0] cmd,
                                                       input int unsigned idx,
                                                       input logic signed [OUT_DW-1:0] val);
        t_heap_result             res;
        int unsigned              n;
        int unsigned              pos;
        int unsigned              left;
        int unsigned              right;
        int unsigned              big;
        int unsigned              swaps;
        logic signed [OUT_DW-1:0] tmp;
        res.read_value     = '0;
        res.final_position = idx[IDX_W-1:0];
        res.swap_count     = '0;
        case (cmd)
            CMD_WRITE: begin
                heap_image[idx]   = val;
                slot_written[idx] = 1'b1;
            end
            CMD_READ: begin
                res.read_value = heap_image[idx];
            end
            CMD_SIFT: begin
                n     = effective_size();
                pos   = idx;
                swaps = 0;
                while (pos < n) begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    big   = pos;
                    // strict compares keep the left child on ties
                    if (left < n && heap_image[left] > heap_image[big]) big = left;
                    if (right < n && heap_image[right] > heap_image[big]) big = right;
                    if (big == pos) break;
                    tmp             = heap_image[pos];
                    heap_image[pos] = heap_image[big];
                    heap_image[big] = tmp;
                    pos             = big;
                    swaps++;
                end
                res.final_position = pos[IDX_W-1:0];
                res.swap_count     = swaps[SWP_W-1:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly random words, with the extremes and a narrow band that breeds ties
    function automatic logic signed [OUT_DW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2, 3:    return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // one request; entered and left at a falling edge, valid is left high so
    // back-to-back requests never drop it
    task automatic send_request(input logic [1:0] cmd, input int unsigned idx,
                                input logic signed [OUT_DW-1:0] val);
        t_heap_result want;
        while (!steady_in && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_index    <= idx[IDX_W-1:0];
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        // accepted at this edge: the image moves on in request order
        want = predict_heap_step(cmd, idx, val);
        pending_results.push_back(want);
        case (cmd)
            CMD_WRITE: write_count++;
            CMD_READ:  read_count++;
            CMD_SIFT: begin
                sift_count++;
                if (want.swap_count > deepest_swaps) deepest_swaps = want.swap_count;
            end
            default:   unused_count++;
        endcase
        @(negedge i_clk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_heap_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // heap_size is only written with the engine idle
    task automatic set_heap_size(input int unsigned size);
        wait_heap_drained();
        i_cfg_valid     <= 1'b1;
        i_cfg_heap_size <= size[HSZ_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        heap_size_reg = size[HSZ_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one random request aimed at the live part of the heap; anything that
    // would touch a never-written slot becomes a write to that slot instead
    task automatic random_heap_op();
        int unsigned n;
        int unsigned span;
        int unsigned pick;
        int unsigned slot;
        int          hole;
        n    = effective_size();
        span = (n + 4 > HEAP_DEPTH) ? HEAP_DEPTH : n + 4;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, span - 1);
        if (pick < 25) begin
            send_request(CMD_WRITE, slot, rand_word());
        end else if (pick < 45) begin
            if (slot_written[slot]) send_request(CMD_READ, slot, $urandom);
            else send_request(CMD_WRITE, slot, rand_word());
        end else if (pick < 82) begin
            // now and then a start anywhere in the memory, mostly past the heap
            if ($urandom_range(0, 9) == 0) slot = $urandom_range(0, HEAP_DEPTH - 1);
            hole = first_unfilled_on_walk(slot);
            if (hole < 0) send_request(CMD_SIFT, slot, $urandom);
            else send_request(CMD_WRITE, hole, rand_word());
        end else if (pick < 87) begin
            send_request(CMD_UNUSED, $urandom_range(0, HEAP_DEPTH - 1), $urandom);
        end else begin
            // replace the root and push it back down, as a pop would
            send_request(CMD_WRITE, 0, rand_word());
            hole = first_unfilled_on_walk(0);
            if (hole < 0) send_request(CMD_SIFT, 0, $urandom);
            else send_request(CMD_WRITE, hole, rand_word());
        end
    endtask

    // fill slots 0..size-1 and heapify bottom up, then random traffic
    task automatic run_heap_phase(input int unsigned size, input int unsigned ops);
        int unsigned n;
        set_heap_size(size);
        n = effective_size();
        for (int unsigned s = 0; s < n; s++) send_request(CMD_WRITE, s, rand_word());
        for (int k = int'(n / 2) - 1; k >= 0; k--) send_request(CMD_SIFT, k, $urandom);
        repeat (ops) random_heap_op();
    endtask

    // leftmost path 0,1,3,...,1023 in falling order with a tiny root: the
    // root sinks through every level, siblings equal or just below the path
    task automatic seq_deep_path();
        logic signed [OUT_DW-1:0] level_val;
        int unsigned              node;
        level_val = 32'sh7000_0000;
        send_request(CMD_WRITE, 0, WORD_MIN + $urandom_range(0, 15));
        for (int unsigned d = 1; d <= 10; d++) begin
            node      = (1 << d) - 1;
            level_val = level_val - $urandom_range(1, 1 << 20);
            send_request(CMD_WRITE, node, level_val);
            if (node + 1 < HEAP_DEPTH)
                send_request(CMD_WRITE, node + 1, level_val - $urandom_range(0, 3));
        end
        send_request(CMD_SIFT, 0, $urandom);
        send_request(CMD_READ, HEAP_DEPTH - 1, $urandom);
        send_request(CMD_READ, 0, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // small hand-built heap: extremes, tie on the children, start past the
    // heap, start at the last index, leaf start, unused command, empty heap
    task automatic test_directed_cases();
        set_heap_size(7);
        send_request(CMD_WRITE, 0, WORD_MIN);
        send_request(CMD_WRITE, 1, WORD_MAX);
        send_request(CMD_WRITE, 2, WORD_MAX);
        send_request(CMD_WRITE, 3, 32'sd5);
        send_request(CMD_WRITE, 4, 32'sd5);
        send_request(CMD_WRITE, 5, -32'sd1);
        send_request(CMD_WRITE, 6, 32'sd0);
        send_request(CMD_SIFT, 0, '0);
        send_request(CMD_READ, 0, '0);
        send_request(CMD_READ, 1, '0);
        send_request(CMD_READ, 3, '0);
        send_request(CMD_SIFT, 7, '0);
        send_request(CMD_SIFT, HEAP_DEPTH - 1, '1);
        send_request(CMD_SIFT, 6, '0);
        send_request(CMD_UNUSED, HEAP_DEPTH - 1, '1);
        send_request(CMD_READ, 2, '0);
        // an empty heap sifts nothing
        set_heap_size(0);
        send_request(CMD_SIFT, 0, '0);
        send_request(CMD_READ, 4, '0);
    endtask

    // ten-level walk with the full depth and with a size past the depth
    task automatic test_deepest_walk();
        set_heap_size(HEAP_DEPTH);
        seq_deep_path();
        set_heap_size((1 << HSZ_W) - 1);
        seq_deep_path();
        repeat (40) random_heap_op();
    endtask

    // well-formed heaps of assorted sizes under random gaps on both sides
    task automatic test_random_heaps();
        run_heap_phase(1, 25);
        run_heap_phase(2, 25);
        run_heap_phase(5, 50);
        run_heap_phase(13, 60);
        run_heap_phase($urandom_range(32, 63), 60);
    endtask

    // no random gaps on either channel: requests back to back, ready always high
    task automatic test_steady_stream();
        steady_in  = 1'b1;
        steady_out = 1'b1;
        run_heap_phase(9, 50);
        wait_heap_drained();
        steady_in  = 1'b0;
        steady_out = 1'b0;
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_heap_drained();
        steady_in     = 1'b1;
        stall_request = 1'b1;
        repeat (40) random_heap_op();
        steady_in = 1'b0;
        wait_heap_drained();
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // ready changes on the falling edge; a stall request holds it low
    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stalls_done++;
            end else if (steady_out) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_heap_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %0d %0d %0d",
                       o_read_value, o_final_position, o_swap_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, o_read_value);
                    mismatch_count++;
                end
                if (o_final_position !== want.final_position) begin
                    $error("final_position: expected %0d, got %0d",
                           want.final_position, o_final_position);
                    mismatch_count++;
                end
                if (o_swap_count !== want.swap_count) begin
                    $error("swap_count: expected %0d, got %0d", want.swap_count, o_swap_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        // every input known from time zero
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_WRITE;
        i_index         = '0;
        i_value         = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_heap_size = '0;
        heap_size_reg   = '0;
        steady_in       = 1'b0;
        steady_out      = 1'b0;
        stall_request   = 1'b0;
        mismatch_count  = 0;
        results_checked = 0;
        write_count     = 0;
        read_count      = 0;
        sift_count      = 0;
        unused_count    = 0;
        deepest_swaps   = 0;
        stalls_done     = 0;
        foreach (slot_written[s]) slot_written[s] = 1'b0;

        // synchronous reset, released on a falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_deepest_walk();
        test_random_heaps();
        test_steady_stream();
        test_output_backpressure();

        // everything answered, then a quiet spell to catch stray results
        wait_heap_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d writes, %0d reads, %0d sift-downs (deepest %0d swaps)",
                 write_count, read_count, sift_count, deepest_swaps);
        $display("%0d unused, %0d results checked over heap sizes 0 to 2047, %0d stall(s)",
                 unused_count, results_checked, stalls_done);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
